/* rtl/lpfd_pkg.sv */
`default_nettype none
package lpfd_pkg;

    localparam int unsigned HEADER_BYTES_DEF = 4;
    localparam int unsigned LEN_W            = 32;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       frame_error;
    } t_result;

endpackage
`default_nettype wire

/* rtl/length_prefix_frame_decoder.sv */
`default_nettype none
// Length-prefixed frame decoder. Takes one stream byte (or a clear request) per clock
// while not stalled and gives at most one result per request: a payload byte with
// first/last marks, or a single error result for a zero or oversized header, after
// which bytes are dropped until a clear. Requests pass through the input register
// and then the result register; the header, length and byte-count state is updated
// between them. The user must write the maximum frame length register through
// i_cfg_wr_en/i_cfg_wr_data only while idle; the block does not enforce it.
module length_prefix_frame_decoder #(
    parameter int unsigned HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [lpfd_pkg::LEN_W-1:0]    i_cfg_wr_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_operation,
    input  wire [7:0]                    i_data_byte,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_first_of_frame,
    output logic                         o_last_of_frame,
    output logic                         o_frame_error
);
    import lpfd_pkg::*;

    logic       in_valid;
    t_op        in_op;
    logic [7:0] in_byte;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // advance when the input register holds a request and the result register is free or draining
    assign advance = in_valid && (!o_out_valid || !i_out_stall);

    lpfd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_advance   (advance),
        .o_in_stall  (o_in_stall),
        .o_valid     (in_valid),
        .o_op        (in_op),
        .o_byte      (in_byte)
    );

    lpfd_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (advance),
        .i_op          (in_op),
        .i_byte        (in_byte),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    lpfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_payload_byte   = out_res.payload_byte;
    assign o_first_of_frame = out_res.first_of_frame;
    assign o_last_of_frame  = out_res.last_of_frame;
    assign o_frame_error    = out_res.frame_error;

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_error |->
            !o_first_of_frame && !o_last_of_frame && o_payload_byte == 8'd0)
        else $error("error result carries payload marks");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

    a_result_needs_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> advance)
        else $error("result produced without advancing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(out_res))
        else $error("stalled result lost or changed");
endmodule
`default_nettype wire

/* rtl/lpfd_in_reg.sv */
`default_nettype none
module lpfd_in_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_operation,
    input  wire [7:0]        i_data_byte,
    input  wire              i_advance,
    output logic             o_in_stall,
    output logic             o_valid,
    output lpfd_pkg::t_op    o_op,
    output logic [7:0]       o_byte
);
    import lpfd_pkg::*;

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    logic [7:0] r_byte;
    logic load;

    assign o_in_stall = r_valid && !i_advance;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // hold request payload until it moves on
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op   <= t_op'(i_operation);
            r_byte <= i_data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_byte  = r_byte;
endmodule
`default_nettype wire

/* rtl/lpfd_core.sv */
`default_nettype none
module lpfd_core #(
    parameter int unsigned HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [lpfd_pkg::LEN_W-1:0]    i_cfg_wr_data,
    input  wire                          i_advance,
    input  lpfd_pkg::t_op                i_op,
    input  wire [7:0]                    i_byte,
    output logic                         o_res_valid,
    output lpfd_pkg::t_result            o_res
);
    import lpfd_pkg::*;

    localparam int unsigned IDX_W    = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HEADER_BYTES - 1);

    logic [LEN_W-1:0] r_max_len;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic [LEN_W-1:0] r_left,  n_left;
    logic             r_in_payload, n_in_payload;
    logic             r_first,      n_first;
    logic             r_err,        n_err;
    logic             r_high,       n_high;

    logic [LEN_W-1:0] acc;
    logic             hi;
    logic             last;

    assign acc  = {r_accum[LEN_W-9:0], i_byte};
    assign hi   = r_high || (r_accum[LEN_W-1:LEN_W-8] != 8'd0);
    assign last = (r_left == LEN_W'(1));

    always_comb begin
        n_idx        = r_idx;
        n_accum      = r_accum;
        n_left       = r_left;
        n_in_payload = r_in_payload;
        n_first      = r_first;
        n_err        = r_err;
        n_high       = r_high;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_advance) begin
            case (i_op)
                OP_CLEAR: begin
                    n_idx        = '0;
                    n_accum      = '0;
                    n_left       = '0;
                    n_in_payload = 1'b0;
                    n_first      = 1'b0;
                    n_err        = 1'b0;
                    n_high       = 1'b0;
                end
                OP_BYTE: begin
                    if (!r_err) begin
                        if (!r_in_payload) begin
                            if (r_idx != HDR_LAST) begin
                                n_idx   = r_idx + IDX_W'(1);
                                n_accum = acc;
                                n_high  = hi;
                            end else begin
                                n_idx   = '0;
                                n_accum = '0;
                                n_high  = 1'b0;
                                if (hi || acc == '0 || acc > r_max_len) begin
                                    n_err             = 1'b1;
                                    o_res_valid       = 1'b1;
                                    o_res.frame_error = 1'b1;
                                end else begin
                                    n_left       = acc;
                                    n_in_payload = 1'b1;
                                    n_first      = 1'b1;
                                end
                            end
                        end else begin
                            o_res_valid          = 1'b1;
                            o_res.payload_byte   = i_byte;
                            o_res.first_of_frame = r_first;
                            o_res.last_of_frame  = last;
                            n_left               = r_left - LEN_W'(1);
                            n_first              = 1'b0;
                            if (last) begin
                                n_in_payload = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_RESET;
            r_idx        <= '0;
            r_accum      <= '0;
            r_left       <= '0;
            r_in_payload <= 1'b0;
            r_first      <= 1'b0;
            r_err        <= 1'b0;
            r_high       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            r_idx        <= n_idx;
            r_accum      <= n_accum;
            r_left       <= n_left;
            r_in_payload <= n_in_payload;
            r_first      <= n_first;
            r_err        <= n_err;
            r_high       <= n_high;
        end
    end
endmodule
`default_nettype wire

/* rtl/lpfd_out_reg.sv */
`default_nettype none
module lpfd_out_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_res_valid,
    input  lpfd_pkg::t_result  i_res,
    input  wire                i_out_stall,
    output logic               o_out_valid,
    output lpfd_pkg::t_result  o_res
);
    import lpfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;
endmodule
`default_nettype wire

/* sim/length_prefix_frame_decoder_tb.sv */
`timescale 1ns / 1ps
module length_prefix_frame_decoder_tb;
    import lpfd_pkg::*;

    class frame_scoreboard;
        logic [LEN_W-1:0] max_len;
        int unsigned      hdr_cnt;
        logic [LEN_W-1:0] len_acc;
        logic [LEN_W-1:0] bytes_left;
        bit               in_payload;
        bit               first_pending;
        bit               err_latched;
        bit               len_high;
        t_result          expected_q[$];
        int               errors;
        int unsigned      live_requests;

        function new();
            max_len = MAX_LEN_RESET;
            errors = 0;
            live_requests = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            hdr_cnt = 0;
            len_acc = '0;
            bytes_left = '0;
            in_payload = 1'b0;
            first_pending = 1'b0;
            err_latched = 1'b0;
            len_high = 1'b0;
        endfunction

        function void note_request(t_op op, logic [7:0] b);
            t_result r;
            if (op == OP_CLEAR) begin
                live_requests++;
                clear_frame();
                return;
            end
            if (err_latched) return;
            live_requests++;
            if (!in_payload) begin
                if (len_acc[LEN_W-1 -: 8] != 8'd0) len_high = 1'b1;
                len_acc = {len_acc[LEN_W-9:0], b};
                hdr_cnt++;
                if (hdr_cnt < HEADER_BYTES_DEF) return;
                hdr_cnt = 0;
                if (len_high || len_acc == '0 || len_acc > max_len) begin
                    err_latched = 1'b1;
                    r = '0;
                    r.frame_error = 1'b1;
                    expected_q = {expected_q, r};
                end else begin
                    bytes_left = len_acc;
                    in_payload = 1'b1;
                    first_pending = 1'b1;
                end
                len_acc = '0;
                len_high = 1'b0;
                return;
            end
            bytes_left--;
            r.payload_byte = b;
            r.first_of_frame = first_pending;
            r.last_of_frame = (bytes_left == '0);
            r.frame_error = 1'b0;
            first_pending = 1'b0;
            if (bytes_left == '0) in_payload = 1'b0;
            expected_q = {expected_q, r};
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: payload_byte %0h frame_error %0b",
                       got.payload_byte, got.frame_error);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %0h, actual %0h",
                       want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.first_of_frame !== want.first_of_frame) begin
                $error("first_of_frame: expected %0b, actual %0b",
                       want.first_of_frame, got.first_of_frame);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0b, actual %0b",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
            if (got.frame_error !== want.frame_error) begin
                $error("frame_error: expected %0b, actual %0b",
                       want.frame_error, got.frame_error);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_op              in_op = OP_BYTE;
    logic [7:0]       in_byte = 8'd0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       res_byte;
    logic             res_first;
    logic             res_last;
    logic             res_error;

    frame_scoreboard sb = new();
    int              burst_left = 0;
    bit              long_hold = 1'b0;

    length_prefix_frame_decoder dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (in_op),
        .i_data_byte      (in_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_payload_byte   (res_byte),
        .o_first_of_frame (res_first),
        .o_last_of_frame  (res_last),
        .o_frame_error    (res_error)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_request(in_op, in_byte);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(t_result'({res_byte, res_first, res_last, res_error}));
    end

    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (long_hold) begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(4, 50);
            end
            left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ~out_stall;
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    task automatic send_req(input t_op op, input logic [7:0] b);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_byte <= b;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic send_header(input logic [LEN_W-1:0] len);
        for (int i = HEADER_BYTES_DEF - 1; i >= 0; i--)
            send_req(OP_BYTE, (i < 4) ? len[8*i +: 8] : 8'd0);
    endtask

    task automatic send_payload(input int unsigned n);
        repeat (n) send_req(OP_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        int guard;
        in_valid <= 1'b0;
        burst_left = 0;
        guard = 0;
        @(posedge clk);
        while (sb.expected_q.size() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.errors++;
            sb.expected_q.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.max_len = v;
    endtask

    task automatic send_good_frame();
        int unsigned      cap;
        logic [LEN_W-1:0] len;
        cap = (sb.max_len < 24) ? sb.max_len : 24;
        len = $urandom_range(1, cap);
        if (sb.max_len <= 64 && $urandom_range(0, 9) == 0) len = sb.max_len;
        send_header(len);
        if ($urandom_range(0, 9) == 0) begin
            send_payload($urandom_range(0, len - 1));
            send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
        end else begin
            send_payload(len);
        end
    endtask

    task automatic send_bad_frame();
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] span;
        len = '0;
        if (sb.max_len != '1) begin
            span = '1 - sb.max_len;
            case ($urandom_range(0, 2))
                0: len = '0;
                1: len = sb.max_len + 1;
                default: len = sb.max_len + 1 + ($urandom % span);
            endcase
        end
        send_header(len);
        send_payload($urandom_range(0, 3));
        if ($urandom_range(0, 9) != 0) send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 3))
            send_req(t_op'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 7) send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] v, input int unsigned target,
                             input bit with_hold);
        int unsigned start;
        int unsigned kind;
        write_max_len(v);
        if (v == '1) begin
            send_header('1);
            send_payload(3);
            send_req(OP_CLEAR, 8'h00);
        end
        if (with_hold) long_hold = 1'b1;
        start = sb.live_requests;
        while (sb.live_requests - start < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) send_good_frame();
            else if (kind < 85) send_bad_frame();
            else send_noise();
        end
        drain_results();
    endtask

    initial begin
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        send_header(32'd1);
        send_req(OP_BYTE, 8'hFF);
        send_header(32'd0);
        send_req(OP_BYTE, 8'h12);
        send_req(OP_CLEAR, 8'hFF);
        send_header(32'h0001_0000);
        send_req(OP_BYTE, 8'h80);
        send_req(OP_BYTE, 8'h7F);
        send_req(OP_CLEAR, 8'h00);
        send_req(OP_BYTE, 8'h00);
        send_req(OP_CLEAR, 8'h00);
        send_header(32'hFFFF_FFFF);
        send_req(OP_CLEAR, 8'h00);
        drain_results();

        run_phase(32'd1, 90, 1'b0);
        run_phase(32'hFFFF_FFFF, 90, 1'b0);
        run_phase(32'd5, 90, 1'b0);
        run_phase(32'd65536, 90, 1'b1);
        run_phase(32'd300, 90, 1'b0);
        run_phase($urandom_range(2, 40), 90, 1'b0);

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lpfd_pkg.sv
rtl/lpfd_in_reg.sv
rtl/lpfd_core.sv
rtl/lpfd_out_reg.sv
rtl/length_prefix_frame_decoder.sv
sim/length_prefix_frame_decoder_tb.sv
